/* rtl/masked_byte_pattern_scan_top_defines.svh */
// Assertion macros shared by the masked byte pattern scanner.
`ifndef MASKED_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH

// Checked at every rising edge outside of reset.
`define MBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define MBPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/mbps_pkg.sv */
// Package with the types, sizes and register indexes of the masked byte pattern scanner.
`default_nettype none
package mbps_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int OFFSET_WIDTH  = 32;
  localparam int REG_BYTES     = 16;
  localparam int REG_BITS      = 8 * REG_BYTES;
  localparam int CFG_WIDTH     = 64;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int LEN_WIDTH     = 5;
  localparam int RES_OFF_WIDTH = 32;
  localparam int SEEN_W        = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_VALUE_LO = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_VALUE_HI = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MASK_LO  = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MASK_HI  = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LENGTH   = 3'd4;

  typedef logic [MAX_PATTERN-1:0][7:0] window_t;

  typedef struct packed {
    logic [REG_BITS-1:0] value;
    logic [REG_BITS-1:0] mask;
  } pattern_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } scan_req_t;

  typedef struct packed {
    logic                     match_found;
    logic [RES_OFF_WIDTH-1:0] match_offset;
  } scan_res_t;

endpackage
`default_nettype wire

/* rtl/mbps_match.sv */
// Parallel masked compare of the pattern against the newest window bytes.
`default_nettype none
module mbps_match (
  input  var mbps_pkg::window_t                  window,
  input  var mbps_pkg::pattern_t                 pattern,
  input  var logic [mbps_pkg::SEEN_W-1:0]        length,
  input  var logic [mbps_pkg::SEEN_W-1:0]        seen,
  output logic                                   hit
);
  import mbps_pkg::*;

  logic [MAX_PATTERN-1:0] mismatch;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
    localparam logic [SEEN_W-1:0] KPLUS = SEEN_W'(k + 1);
    logic [SEEN_W-1:0] idx_full;
    logic [7:0]        value;
    logic [7:0]        mask;
    logic [7:0]        win;

    if (k < REG_BYTES) begin : g_reg
      assign value = pattern.value[8*k +: 8];
      assign mask  = pattern.mask[8*k +: 8];
    end else begin : g_wild
      assign value = 8'h00;
      assign mask  = 8'h00;
    end

    // Pattern byte k lines up with the window byte that is length-1-k places old.
    assign idx_full    = length - KPLUS;
    assign win         = window[idx_full[IDX_W-1:0]];
    assign mismatch[k] = (length >= KPLUS) && (((win ^ value) & mask) != 8'h00);
  end

  assign hit = (seen >= length) && (mismatch == '0);

endmodule
`default_nettype wire

/* rtl/masked_byte_pattern_scan_top.sv */
// Top level of the masked byte pattern scanner: registers, window, offset and result stage.
// A result is registered and shown in the cycle after its request is accepted.
// Throughput: one request per cycle, set by the single result register.
// A request is held off only while a shown result is stalled downstream.
// Reset clears the pattern registers, the window, the byte count, the offset and
// the result valid; the pattern length resets to one.
`default_nettype none
module masked_byte_pattern_scan_top (
  input  var logic                                   clk,
  input  var logic                                   rst,
  input  var logic                                   cfg_write,
  input  var logic [mbps_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  var logic [mbps_pkg::CFG_WIDTH-1:0]         cfg_data,
  input  var logic                                   byte_valid,
  output logic                                       byte_stall,
  input  var mbps_pkg::scan_req_t                    byte_req,
  output logic                                       result_valid,
  input  var logic                                   result_stall,
  output mbps_pkg::scan_res_t                        result
);
  import mbps_pkg::*;
  `include "masked_byte_pattern_scan_top_defines.svh"

  pattern_t                pattern;
  logic [LEN_WIDTH-1:0]    pattern_length;
  window_t                 window;
  window_t                 window_next;
  logic [SEEN_W-1:0]       seen;
  logic [SEEN_W-1:0]       seen_base;
  logic [SEEN_W-1:0]       seen_next;
  logic [OFFSET_WIDTH-1:0] position;
  logic [OFFSET_WIDTH-1:0] cur;
  logic [OFFSET_WIDTH-1:0] start;
  logic [SEEN_W-1:0]       length;
  logic                    accept;
  logic                    hit;

  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= LEN_WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VALUE_LO: pattern.value[CFG_WIDTH-1:0]        <= cfg_data;
        REG_VALUE_HI: pattern.value[REG_BITS-1:CFG_WIDTH] <= cfg_data;
        REG_MASK_LO:  pattern.mask[CFG_WIDTH-1:0]         <= cfg_data;
        REG_MASK_HI:  pattern.mask[REG_BITS-1:CFG_WIDTH]  <= cfg_data;
        REG_LENGTH:   pattern_length                      <= cfg_data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      length = SEEN_W'(1);
    end else if (pattern_length > MAX_PATTERN) begin
      length = SEEN_W'(MAX_PATTERN);
    end else begin
      length = SEEN_W'(pattern_length);
    end
  end

  // The first byte of an image clears the window, the count and the offset before it enters.
  always_comb begin
    if (byte_req.first_byte) begin
      window_next = '0;
      seen_base   = '0;
      cur         = '0;
    end else begin
      window_next = window;
      seen_base   = seen;
      cur         = position;
    end
    for (int a = MAX_PATTERN - 1; a > 0; a--) begin
      window_next[a] = window_next[a-1];
    end
    window_next[0] = byte_req.data_byte;
    if (seen_base < SEEN_W'(MAX_PATTERN)) begin
      seen_next = seen_base + SEEN_W'(1);
    end else begin
      seen_next = seen_base;
    end
  end

  assign start = cur - OFFSET_WIDTH'(length - SEEN_W'(1));

  mbps_match u_match (
    .window  (window_next),
    .pattern (pattern),
    .length  (length),
    .seen    (seen_next),
    .hit     (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      seen         <= '0;
      position     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        window       <= window_next;
        seen         <= seen_next;
        position     <= cur + OFFSET_WIDTH'(1);
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.match_found  <= hit;
      result.match_offset <= hit ? RES_OFF_WIDTH'(start) : '0;
    end
  end

  `MBPS_ASSERT(a_accept_shows_result, accept |=> result_valid, "accepted request gave no result")
  `MBPS_ASSERT(a_miss_zero_offset, result_valid && !result.match_found |-> result.match_offset == '0, "offset set without a match")
  `MBPS_ASSERT(a_first_restarts, accept && byte_req.first_byte |=> seen == SEEN_W'(1) && position == OFFSET_WIDTH'(1), "first byte did not restart the image")
  `MBPS_ASSERT(a_match_needs_bytes, result_valid && result.match_found |-> seen >= length, "match reported before the window was full")
  `MBPS_ASSERT(a_seen_bounded, seen <= SEEN_W'(MAX_PATTERN), "byte count ran past the window depth")

endmodule
`default_nettype wire
